>>> sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int unsigned WIN_SIZE        = 9;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned CFG_W           = 13;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned DEF_MAX_WIDTH   = 4096;
  localparam int unsigned DEF_MAX_HEIGHT  = 4096;
  localparam int unsigned RESET_WIDTH     = 640;
  localparam int unsigned RESET_HEIGHT    = 480;
  localparam logic [PIX_W-1:0] PIX_MIN    = 8'h00;
  localparam logic [PIX_W-1:0] PIX_MAX    = 8'hFF;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_SIZE-1:0] win_t;
  typedef logic [WIN_SIZE-1:0] win_mask_t;

  // Register select, taken from the word address bit
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_sel_e;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } out_tag_t;

  function automatic pix_t min8(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max8(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

  // Pick which clipped positions pad low (zero) so that the 9-point median
  // lands on entry floor(n/2) of the n real neighbours; the rest pad high.
  function automatic win_mask_t pad_low(win_mask_t mask);
    logic [3:0] n;
    logic [3:0] lows;
    logic [3:0] rank;
    win_mask_t  res;
    n    = 4'($countones(mask));
    lows = 4'd4 - (n >> 1);
    rank = 4'd0;
    res  = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      if (!mask[i]) begin
        res[i] = (rank < lows);
        rank   = rank + 4'd1;
      end
    end
    return res;
  endfunction

endpackage

>>> sv/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mf3_median9.sv
// ----------------------------------------------------------------------------
// mf3_median9
// Pipelined 9-point median: pad clipped taps, sort rows, combine columns.
// ----------------------------------------------------------------------------
module mf3_median9 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mf3_pkg::win_t      win_i,
  input  mf3_pkg::win_mask_t mask_i,
  input  mf3_pkg::win_mask_t pad_low_i,
  input  mf3_pkg::out_tag_t  tag_i,
  output logic               valid_o,
  output mf3_pkg::pix_t      median_o,
  output mf3_pkg::out_tag_t  tag_o
);

  mf3_pkg::win_t     padded;
  mf3_pkg::pix_t     lo_q [3];
  mf3_pkg::pix_t     mi_q [3];
  mf3_pkg::pix_t     hi_q [3];
  mf3_pkg::pix_t     b_lo_q, b_mi_q, b_hi_q;
  logic              a_valid_q, b_valid_q;
  mf3_pkg::out_tag_t a_tag_q, b_tag_q;

  always_comb begin
    for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
      if (mask_i[i]) begin
        padded[i] = win_i[i];
      end else begin
        padded[i] = pad_low_i[i] ? mf3_pkg::PIX_MIN : mf3_pkg::PIX_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        lo_q[r] <= mf3_pkg::min8(mf3_pkg::min8(padded[3*r], padded[3*r+1]), padded[3*r+2]);
        mi_q[r] <= mf3_pkg::med3(padded[3*r], padded[3*r+1], padded[3*r+2]);
        hi_q[r] <= mf3_pkg::max8(mf3_pkg::max8(padded[3*r], padded[3*r+1]), padded[3*r+2]);
      end
      a_tag_q <= tag_i;
      b_lo_q  <= mf3_pkg::max8(mf3_pkg::max8(lo_q[0], lo_q[1]), lo_q[2]);
      b_mi_q  <= mf3_pkg::med3(mi_q[0], mi_q[1], mi_q[2]);
      b_hi_q  <= mf3_pkg::min8(mf3_pkg::min8(hi_q[0], hi_q[1]), hi_q[2]);
      b_tag_q <= a_tag_q;
    end
  end

  assign valid_o  = b_valid_q;
  assign median_o = mf3_pkg::med3(b_lo_q, b_mi_q, b_hi_q);
  assign tag_o    = b_tag_q;

endmodule

>>> sv/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata = pixel_value, tuser = flush. Pixels arrive in raster
//   order; a flush transfer drains one pending output once the whole image
//   has arrived and is dropped before that.
//   Master stream: tdata = median_value, tuser = row_end, tlast = frame_end.
//   Each output belongs to the pixel one row plus one pixel behind the input,
//   so width+1 flush transfers after the image drain the last outputs.
//   APB port: image_width at 0x0, image_height at 0x4, clamped to the
//   supported range; a write restarts the frame position (write while idle).
// Throughput: one transfer per clock while the pipeline is not stalled. A
//   result passes the line store read, the window shift, the sort pipeline
//   and the output register after the transfer that produces it.
// Reset: counters restart, window clears, size returns to 640 x 480. The
//   line stores are not cleared; unwritten entries only reach clipped taps.
// Stall: while the output register holds a transfer the receiver has not
//   taken, the whole pipeline and that transfer hold and slave tready drops.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Slave stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] pixel_value
  input  logic                            s_axis_tuser,  // [0] flush
  // Master stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] median_value
  output logic                            m_axis_tuser,  // [0] row_end
  output logic                            m_axis_tlast,  // frame_end
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mf3_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mf3_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mf3_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);        // column index
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);    // width value
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);   // height / out row
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 3);   // input row, runs past
  localparam int unsigned RST_W = (mf3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                                  MAX_WIDTH : mf3_pkg::RESET_WIDTH;
  localparam int unsigned RST_H = (mf3_pkg::RESET_HEIGHT > MAX_HEIGHT) ?
                                  MAX_HEIGHT : mf3_pkg::RESET_HEIGHT;

  // Configuration
  logic [WW-1:0]   width_q;
  logic [HW-1:0]   height_q;
  logic            cfg_wr;
  mf3_pkg::reg_sel_e cfg_sel;
  logic [mf3_pkg::CFG_W-1:0] cfg_val;

  // Position counters
  logic [CW-1:0]   in_col_q, in_col_d;
  logic [RW-1:0]   in_row_q, in_row_d;
  logic [CW-1:0]   out_col_q, out_col_d;
  logic [HW-1:0]   out_row_q, out_row_d;

  // Stage 1: line store read in flight
  logic              s1_valid_q;
  logic [CW-1:0]     s1_col_q;
  mf3_pkg::pix_t     s1_pix_q;
  logic              s1_emit_q;
  mf3_pkg::win_mask_t s1_mask_q, s1_pad_q;
  mf3_pkg::out_tag_t s1_tag_q;
  logic              s1_fwd_q;
  mf3_pkg::pix_t     s1_fwd_top_q, s1_fwd_mid_q;

  // Stage 2: window holds the shifted neighbourhood
  mf3_pkg::win_t     win_q;
  logic              s2_valid_q;
  mf3_pkg::win_mask_t s2_mask_q, s2_pad_q;
  mf3_pkg::out_tag_t s2_tag_q;

  // Output register
  logic              m_valid_q;
  mf3_pkg::pix_t     m_data_q;
  mf3_pkg::out_tag_t m_tag_q;

  logic              adv, accept, take, draining, emit;
  logic              row_end, frame_end;
  logic [WW-1:0]     in_col_inc, out_col_inc;
  logic [HW-1:0]     out_row_inc;
  mf3_pkg::pix_t     in_pix, rd_top, rd_mid, top, mid;
  mf3_pkg::win_mask_t mask;
  mf3_pkg::out_tag_t tag;
  logic              med_valid;
  mf3_pkg::pix_t     med_value;
  mf3_pkg::out_tag_t med_tag;

  // --------------------------------------------------------------------------
  // APB: write on the access phase, word select by address bit 2
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = mf3_pkg::reg_sel_e'(paddr[2]);
  assign cfg_val = pwdata[mf3_pkg::CFG_W-1:0];

  always_comb begin
    case (cfg_sel)
      mf3_pkg::REG_IMAGE_WIDTH:  prdata = mf3_pkg::APB_DATA_W'(width_q);
      mf3_pkg::REG_IMAGE_HEIGHT: prdata = mf3_pkg::APB_DATA_W'(height_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(RST_H);
    end else if (cfg_wr) begin
      case (cfg_sel)
        mf3_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_val == '0) width_q <= WW'(1);
          else if (32'(cfg_val) > MAX_WIDTH) width_q <= WW'(MAX_WIDTH);
          else width_q <= WW'(cfg_val);
        end
        mf3_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_val == '0) height_q <= HW'(1);
          else if (32'(cfg_val) > MAX_HEIGHT) height_q <= HW'(MAX_HEIGHT);
          else height_q <= HW'(cfg_val);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: accept, position bookkeeping, line store read
  // --------------------------------------------------------------------------
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign draining      = in_row_q >= RW'(height_q);
  // Drop a flush that arrives before the image is complete
  assign take          = accept && !(s_axis_tuser && !draining);
  assign in_pix        = draining ? mf3_pkg::PIX_MIN : s_axis_tdata;
  assign emit          = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));

  assign in_col_inc  = WW'(in_col_q) + WW'(1);
  assign out_col_inc = WW'(out_col_q) + WW'(1);
  assign out_row_inc = out_row_q + HW'(1);
  assign row_end     = out_col_inc >= width_q;
  assign frame_end   = row_end && (out_row_inc >= height_q);

  // Taps inside the image, index row*3 + column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask[3*r+c] = !((r == 0) && (out_row_q == '0)) &&
                      !((r == 2) && (out_row_inc >= height_q)) &&
                      !((c == 0) && (out_col_q == '0)) &&
                      !((c == 2) && row_end);
      end
    end
  end

  assign tag.row_end   = row_end;
  assign tag.frame_end = frame_end;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      if (in_col_inc >= width_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = CW'(in_col_inc);
      end
      if (emit) begin
        if (frame_end) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (row_end) begin
          out_col_d = '0;
          out_row_d = out_row_inc;
        end else begin
          out_col_d = CW'(out_col_inc);
        end
      end
    end
    // A register write starts a new frame
    if (cfg_wr) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: read data back, rotate the column through both line stores
  // --------------------------------------------------------------------------
  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (rd_top)
  );

  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (rd_mid)
  );

  // Forward the write that lands at the same edge as the read of the same
  // column (one-pixel rows, and the first column after a frame restart)
  assign top = s1_fwd_q ? s1_fwd_top_q : rd_top;
  assign mid = s1_fwd_q ? s1_fwd_mid_q : rd_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= take;
      s1_fwd_q   <= take && s1_valid_q && (s1_col_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q     <= in_col_q;
      s1_pix_q     <= in_pix;
      s1_emit_q    <= emit;
      s1_mask_q    <= mask;
      s1_pad_q     <= mf3_pkg::pad_low(mask);
      s1_tag_q     <= tag;
      s1_fwd_top_q <= mid;
      s1_fwd_mid_q <= s1_pix_q;
    end
  end

  // Shift the window one column and load the new right-hand column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      if (s1_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[3*r]   <= win_q[3*r+1];
          win_q[3*r+1] <= win_q[3*r+2];
        end
        win_q[2] <= top;
        win_q[5] <= mid;
        win_q[8] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mask_q <= s1_mask_q;
      s2_pad_q  <= s1_pad_q;
      s2_tag_q  <= s1_tag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3-4: sort network, then the output register
  // --------------------------------------------------------------------------
  mf3_median9 u_median (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (s2_valid_q),
    .win_i     (win_q),
    .mask_i    (s2_mask_q),
    .pad_low_i (s2_pad_q),
    .tag_i     (s2_tag_q),
    .valid_o   (med_valid),
    .median_o  (med_value),
    .tag_o     (med_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= med_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= med_value;
      m_tag_q  <= med_tag;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_tag_q.row_end;
  assign m_axis_tlast  = m_tag_q.frame_end;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_frame_end_on_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tlast || m_axis_tuser))
    else $error("frame end without row end");

  a_fwd_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q)
    else $error("line store forwarding without an item in stage 1");

  a_stage1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_col_q)))
    else $error("stage 1 lost its item during a stall");

  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < width_q || $past(cfg_wr))
    else $error("input column beyond image width");

endmodule
